// ===== rtl/button_debounce_long_press_repeat_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce unit
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_ASSERT_SVH

// Same-cycle implication
`define BDLPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button debounce: same-cycle check failed");

// Next-cycle implication
`define BDLPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button debounce: next-cycle check failed");

`endif

// ===== rtl/bdlpr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlpr_pkg
// Shared types, register indexes and reset values of the debounce unit.
// ----------------------------------------------------------------------------
package bdlpr_pkg;

    // Default timestamp width
    localparam int TIME_BITS_DEF = 32;

    // Field widths
    localparam int NOW_W   = 32;
    localparam int DEB_W   = 16;
    localparam int LONG_W  = 32;
    localparam int HOLD_W  = 32;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;
    localparam int IN_DW   = 40;
    localparam int OUT_DW  = 8;

    // Register reset values
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST    = 16'd50;
    localparam logic              LOW_PRESSED_RST = 1'b1;
    localparam logic [LONG_W-1:0] LONG_PRESS_RST  = 32'd1000;
    localparam logic [HOLD_W-1:0] HOLD_INT_RST    = 32'd200;
    localparam logic              LONG_EN_RST     = 1'b0;
    localparam logic              HOLD_EN_RST     = 1'b0;

    // Register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_LOW_PRESSED = 3'd1,
        REG_LONG_PRESS  = 3'd2,
        REG_HOLD_INT    = 3'd3,
        REG_LONG_EN     = 3'd4,
        REG_HOLD_EN     = 3'd5
    } cfg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic              low_pressed;
        logic [LONG_W-1:0] long_press_ms;
        logic [HOLD_W-1:0] hold_interval_ms;
        logic              long_press_enable;
        logic              hold_enable;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic is_down;
        logic hold_event;
        logic long_press_event;
        logic released_event;
        logic pressed_event;
    } result_t;

endpackage

// ===== rtl/bdlpr_cfg.sv =====
// ----------------------------------------------------------------------------
// bdlpr_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module bdlpr_cfg
    import bdlpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_DEBOUNCE:    cfg_next.debounce_ms       = cfg_wdata[DEB_W-1:0];
                REG_LOW_PRESSED: cfg_next.low_pressed       = cfg_wdata[0];
                REG_LONG_PRESS:  cfg_next.long_press_ms     = cfg_wdata[LONG_W-1:0];
                REG_HOLD_INT:    cfg_next.hold_interval_ms  = cfg_wdata[HOLD_W-1:0];
                REG_LONG_EN:     cfg_next.long_press_enable = cfg_wdata[0];
                REG_HOLD_EN:     cfg_next.hold_enable       = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= DEBOUNCE_RST;
            cfg_reg.low_pressed       <= LOW_PRESSED_RST;
            cfg_reg.long_press_ms     <= LONG_PRESS_RST;
            cfg_reg.hold_interval_ms  <= HOLD_INT_RST;
            cfg_reg.long_press_enable <= LONG_EN_RST;
            cfg_reg.hold_enable       <= HOLD_EN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bdlpr_core.sv =====
// ----------------------------------------------------------------------------
// bdlpr_core
// Debounce, press tracking and long-press / hold timing for one sample.
// ----------------------------------------------------------------------------
module bdlpr_core
    import bdlpr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             accept,
    input  logic             raw_level,
    input  logic [NOW_W-1:0] now_ms,
    output result_t          result
);

    // Compare width covers both the time span and the 32-bit thresholds
    localparam int CMP_W = (TIME_BITS > LONG_W) ? TIME_BITS : LONG_W;

    logic                 prev_raw_reg, prev_raw_next;
    logic                 stable_reg, stable_next;
    logic [TIME_BITS-1:0] change_time_reg, change_time_next;
    logic [TIME_BITS-1:0] press_start_reg, press_start_next;
    logic                 long_fired_reg, long_fired_next;
    logic                 rep_started_reg, rep_started_next;
    logic [TIME_BITS-1:0] rep_time_reg, rep_time_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] quiet_span;
    logic [TIME_BITS-1:0] press_span;
    logic [TIME_BITS-1:0] rep_span;
    logic                 level_ok;
    logic                 new_press;
    logic                 down;
    logic                 reached;
    logic                 long_fired_eff;
    logic                 rep_started_eff;
    logic                 hold_go;

    assign now_t = TIME_BITS'(now_ms);

    // Step logic
    always_comb
    begin
        result           = '0;
        prev_raw_next    = raw_level;
        change_time_next = (raw_level != prev_raw_reg) ? now_t : change_time_reg;
        quiet_span       = now_t - change_time_next;

        // Accept the raw level once it has been quiet long enough
        level_ok    = (CMP_W'(quiet_span) > CMP_W'(cfg.debounce_ms))
                      && (raw_level != stable_reg);
        stable_next = level_ok ? raw_level : stable_reg;
        down        = (stable_next == ~cfg.low_pressed);
        new_press   = level_ok && down;
        result.pressed_event  = new_press;
        result.released_event = level_ok && !down;

        press_start_next = new_press ? now_t : press_start_reg;
        long_fired_eff   = new_press ? 1'b0 : long_fired_reg;
        rep_started_eff  = new_press ? 1'b0 : rep_started_reg;

        // Press duration is zero in the step that starts a press
        press_span = now_t - press_start_reg;
        reached    = new_press ? (cfg.long_press_ms == '0)
                               : (CMP_W'(press_span) >= CMP_W'(cfg.long_press_ms));

        // One-shot long press
        result.long_press_event = down && cfg.long_press_enable
                                  && !long_fired_eff && reached;
        long_fired_next = long_fired_eff | result.long_press_event;

        // Hold repeat timing
        rep_span = now_t - rep_time_reg;
        hold_go  = down && cfg.hold_enable && reached
                   && (!rep_started_eff
                       || (CMP_W'(rep_span) >= CMP_W'(cfg.hold_interval_ms)));
        result.hold_event = hold_go && (rep_started_eff || !cfg.long_press_enable);
        rep_time_next    = hold_go ? now_t : rep_time_reg;
        rep_started_next = rep_started_eff | hold_go;

        result.is_down = down;
    end

    // Advance the state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
            press_start_reg <= '0;
            long_fired_reg  <= 1'b0;
            rep_started_reg <= 1'b0;
            rep_time_reg    <= '0;
        end
        else if (accept)
        begin
            prev_raw_reg    <= prev_raw_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
            press_start_reg <= press_start_next;
            long_fired_reg  <= long_fired_next;
            rep_started_reg <= rep_started_next;
            rep_time_reg    <= rep_time_next;
        end
    end

endmodule

// ===== rtl/button_debounce_long_press_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_unit
// The result of an accepted sample beat is registered and presented in the next cycle.
// Throughput: one sample per cycle while results are taken; the result register frees as it is taken.
// The per-sample state update is a single pass of compare logic.
// Reset: state, configuration and result valid return to their defaults; result data is not reset.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat_unit
    import bdlpr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Sample stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // [0] raw_level, [32:1] now_ms, rest zero
    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // [0] pressed_event, [1] released_event,
                                              // [2] long_press_event, [3] hold_event,
                                              // [4] is_down, rest zero
    // Configuration write port
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

`include "button_debounce_long_press_repeat_unit_assert.svh"

    cfg_t    cfg;
    result_t step_res;
    logic    in_accept;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic    both_edges;
    logic    down_event;

    bdlpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bdlpr_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (in_accept),
        .raw_level (s_axis_tdata[0]),
        .now_ms    (s_axis_tdata[NOW_W:1]),
        .result    (step_res)
    );

    // Take a beat whenever the result register is empty or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= step_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'(out_data_reg);

    // Checks
    assign both_edges = out_data_reg.pressed_event && out_data_reg.released_event;
    assign down_event = out_data_reg.hold_event || out_data_reg.long_press_event
                        || out_data_reg.pressed_event;

    `BDLPR_ASSERT_NXT(a_beat_lands, in_accept, m_axis_tvalid)
    `BDLPR_ASSERT_IMP(a_press_release_excl, m_axis_tvalid, !both_edges)
    `BDLPR_ASSERT_IMP(a_events_need_down, m_axis_tvalid && down_event, out_data_reg.is_down)
    `BDLPR_ASSERT_IMP(a_release_is_up, m_axis_tvalid && out_data_reg.released_event, !out_data_reg.is_down)

endmodule
